FILE: rtl/rkc_pkg.sv
// shared types and constants for the rgb 3x3 convolution block
`timescale 1ns / 1ps
`default_nettype none

package rkc_pkg;

   // pixel and tap widths
   localparam int PIX_W  = 8;
   localparam int NUM_CH = 3;
   localparam int TAP_W  = 16;
   localparam int KROWS  = 3;
   localparam int KCOLS  = 3;
   localparam int KTAPS  = KROWS * KCOLS;

   // merged column coefficient: up to three taps added together
   localparam int COEF_W = TAP_W + 2;
   // unsigned pixel (as signed) times coefficient
   localparam int PROD_W = PIX_W + 1 + COEF_W;
   // sum of the three products in one column
   localparam int CSUM_W = PROD_W + 2;
   // sum of the three column sums
   localparam int ACC_W  = CSUM_W + 2;

   localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
   localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

   // output queue
   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // channel 0 red, 1 green, 2 blue
   typedef logic [NUM_CH-1:0][PIX_W-1:0] pixel_type;
   // row 0 top, row 2 bottom
   typedef pixel_type [KROWS-1:0] column_type;

   typedef logic signed [COEF_W-1:0] coef_type;
   typedef coef_type [KROWS-1:0] coef_col_type;

   typedef logic signed [CSUM_W-1:0] csum_type;
   typedef csum_type [NUM_CH-1:0] csum_col_type;

   typedef struct packed {
      logic      frame_end;
      pixel_type pix;
   } rsp_item_type;

endpackage

`default_nettype wire

FILE: rtl/rkc_cell.sv
// one window column cell: holds a pixel column, multiplies it by its taps
`timescale 1ns / 1ps
`default_nettype none

module rkc_cell
   import rkc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         shift_en,
   input  wire column_type   col_in,
   input  wire coef_col_type coef_in,
   output column_type        col_out,
   output csum_col_type      csum_out
);

   column_type               col_ff;
   logic signed [PROD_W-1:0] prod_ff [KROWS][NUM_CH];
   csum_col_type             csum_ff;

   // column shifts in from the right-hand neighbor on every push
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_ff <= col_in;
      end
   end

   // per row and channel products
   always_ff @(posedge clock) begin
      for (int r = 0; r < KROWS; r++) begin
         for (int ch = 0; ch < NUM_CH; ch++) begin
            prod_ff[r][ch] <= $signed({1'b0, col_ff[r][ch]}) * $signed(coef_in[r]);
         end
      end
   end

   // column sum per channel
   always_ff @(posedge clock) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         csum_ff[ch] <= CSUM_W'(prod_ff[0][ch]) + CSUM_W'(prod_ff[1][ch])
                        + CSUM_W'(prod_ff[2][ch]);
      end
   end

   assign col_out  = col_ff;
   assign csum_out = csum_ff;

endmodule

`default_nettype wire

FILE: rtl/rkc_fifo.sv
// small result queue between the filter pipeline and the response port
`timescale 1ns / 1ps
`default_nettype none

module rkc_fifo
   import rkc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_en,
   input  wire rsp_item_type push_item,
   input  wire logic         pop_en,
   output rsp_item_type      head_item,
   output logic              not_empty
);

   rsp_item_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   // storage
   always_ff @(posedge clock) begin
      if (push_en) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_en) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(1);
         end
         if (pop_en) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_ff + (FIFO_AW+1)'(push_en) - (FIFO_AW+1)'(pop_en);
      end
   end

   assign head_item = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);

endmodule

`default_nettype wire

FILE: rtl/rgb_kernel_convolution_3x3.sv
// top level of the rgb 3x3 convolution with replicated borders
//
// Requests come in raster order on req_*: action 0 carries a pixel, action 1
// drains one pending result once the whole frame is in. Results leave on
// rsp_* with frame_end set on the last pixel of the frame. A result belongs to
// the pixel one row plus one pixel before the request that produces it.
// The csr_* port writes width, height and the nine signed taps; the user must
// use it only while the block is idle, which the block itself does not enforce.
// Width and height writes restart the frame. Throughput is one request per
// cycle while fewer than 8 results are owed; the single exception is the first
// drain of a one-row frame, which runs two pushes through the row stores and
// holds req_ready low for one extra cycle. From request acceptance to rsp_valid
// a result passes the row store read, window shift, product stage and column
// sum, then the final add and clamp. An 8-entry result queue sits before the
// response port; requests are taken while results wait there, and req_ready
// also falls when 8 results are queued or in flight. Reset clears all counters
// and the queue and loads the default registers; the row stores need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module rgb_kernel_convolution_3x3
   import rkc_pkg::*;
#(
   parameter int MAX_WIDTH     = 1024,
   parameter int TAP_FRAC_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_red_in,
   input  wire logic [7:0]  req_green_in,
   input  wire logic [7:0]  req_blue_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_red_out,
   output logic [7:0]       rsp_green_out,
   output logic [7:0]       rsp_blue_out,
   output logic             rsp_frame_end,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int WCW = $clog2(MAX_WIDTH + 1);
   localparam int LW  = WCW + 1;

   localparam logic ACT_PIXEL = 1'b0;

   localparam logic [2:0] CSR_WIDTH      = 3'd0;
   localparam logic [2:0] CSR_HEIGHT     = 3'd1;
   localparam logic [2:0] CSR_TAPS_FIRST = 3'd2;
   localparam logic [2:0] CSR_TAPS_NEXT  = 3'd3;
   localparam logic [2:0] CSR_TAP_LAST   = 3'd4;

   localparam logic [1:0] ROW_FIRST  = 2'd0;
   localparam logic [1:0] ROW_SECOND = 2'd1;
   localparam logic [1:0] ROW_OTHER  = 2'd2;

   typedef struct packed {
      logic emit;
      logic frame_end;
      logic left_rep;
      logic right_rep;
   } push_ctrl_type;

   // configuration registers
   logic [10:0] width_ff;
   logic [15:0] height_ff;
   logic [63:0] taps_lo_ff;
   logic [63:0] taps_hi_ff;
   logic [15:0] tap_last_ff;

   // frame counters
   logic [AW-1:0]          in_col_ff, in_col_in;
   logic [15:0]            in_row_ff, in_row_in;
   logic [AW-1:0]          out_col_ff, out_col_in;
   logic [15:0]            out_row_ff, out_row_in;
   logic [LW-1:0]          lead_ff, lead_in;
   logic                   extra_ff, extra_in;
   logic [FIFO_AW:0]       pending_ff, pending_in;

   logic [WCW-1:0] w_eff;
   logic [15:0]    h_eff;

   logic accept, is_pixel, push_go, push_real, size_write;

   // push control
   logic           base_clear;
   logic [AW-1:0]  b_in_col, b_out_col;
   logic [15:0]    b_in_row, b_out_row;
   logic [LW-1:0]  b_lead, lead_inc;
   logic [AW-1:0]  c_sel;
   logic [WCW-1:0] c_inc, oc_inc;
   logic           col_wrap;
   push_ctrl_type  ctrl_now;
   logic [1:0]     rowsel_now;

   // window stage
   pixel_type      mem_new [MAX_WIDTH];
   pixel_type      mem_old [MAX_WIDTH];
   pixel_type      rd_new_ff, rd_old_ff;
   pixel_type      fwd_new_ff, fwd_old_ff;
   logic           w_vld_ff, w_real_ff, w_fwd_ff;
   pixel_type      w_pix_ff;
   logic [AW-1:0]  w_c_ff;
   logic [1:0]     w_rowsel_ff;
   push_ctrl_type  w_ctrl_ff;
   pixel_type      on_pix, oo_pix, v_pix, top_pix, mid_pix;
   column_type     new_col;

   // cells and coefficients
   logic signed [TAP_W-1:0] tap_val [KTAPS];
   coef_col_type   coef_in [KCOLS];
   coef_col_type   coef_ff [KCOLS];
   column_type     cell_in [KCOLS];
   column_type     cell_col [KCOLS];
   csum_col_type   cell_sum [KCOLS];

   // result pipeline
   logic           c1_vld_ff, c2_vld_ff, c3_vld_ff;
   logic           c1_fend_ff, c2_fend_ff, c3_fend_ff;
   logic signed [ACC_W-1:0] acc [NUM_CH];
   rsp_item_type   res_item, head_item;
   logic           fifo_ne, pop;

   // effective frame size
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WCW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(width_ff);
      end
      h_eff = (height_ff == '0) ? 16'd1 : height_ff;
   end

   // request handshake
   assign req_ready = !extra_ff && (pending_ff < (FIFO_AW+1)'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;
   assign is_pixel  = (req_action == ACT_PIXEL);
   assign push_go   = extra_ff || (accept && (is_pixel || (in_row_ff >= h_eff)));
   assign push_real = !extra_ff && is_pixel;
   assign size_write = csr_we && ((csr_index == CSR_WIDTH) || (csr_index == CSR_HEIGHT));

   // one push through the window: addresses, borders and counter updates
   always_comb begin
      base_clear = push_real && (in_row_ff >= h_eff);
      b_in_col   = base_clear ? '0 : in_col_ff;
      b_in_row   = base_clear ? '0 : in_row_ff;
      b_out_col  = base_clear ? '0 : out_col_ff;
      b_out_row  = base_clear ? '0 : out_row_ff;
      b_lead     = base_clear ? '0 : lead_ff;

      c_sel    = (WCW'(b_in_col) < w_eff) ? b_in_col : '0;
      c_inc    = WCW'(c_sel) + WCW'(1);
      col_wrap = (c_inc >= w_eff);
      in_col_in = col_wrap ? '0 : AW'(c_inc);
      in_row_in = (col_wrap && push_real && (b_in_row < h_eff)) ? b_in_row + 16'd1
                                                                 : b_in_row;

      lead_inc           = b_lead + LW'(1);
      ctrl_now.emit      = (lead_inc > (LW'(w_eff) + LW'(1)));
      ctrl_now.frame_end = ctrl_now.emit && (b_out_row >= (h_eff - 16'd1))
                           && (WCW'(b_out_col) >= (w_eff - WCW'(1)));
      ctrl_now.left_rep  = (c_sel == AW'(1)) || (w_eff == WCW'(1));
      ctrl_now.right_rep = (c_sel == '0);

      oc_inc     = WCW'(b_out_col) + WCW'(1);
      out_col_in = b_out_col;
      out_row_in = b_out_row;
      lead_in    = lead_inc;
      if (ctrl_now.emit) begin
         lead_in = LW'(w_eff) + LW'(1);
         if (ctrl_now.frame_end) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lead_in    = '0;
         end else if (oc_inc >= w_eff) begin
            out_col_in = '0;
            out_row_in = b_out_row + 16'd1;
         end else begin
            out_col_in = AW'(oc_inc);
         end
      end

      if (push_real) begin
         if (b_in_row == 16'd0) begin
            rowsel_now = ROW_FIRST;
         end else if (b_in_row == 16'd1) begin
            rowsel_now = ROW_SECOND;
         end else begin
            rowsel_now = ROW_OTHER;
         end
      end else begin
         rowsel_now = (h_eff == 16'd1) ? ROW_SECOND : ROW_OTHER;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= 11'd640;
         height_ff   <= 16'd480;
         taps_lo_ff  <= 64'd0;
         taps_hi_ff  <= 64'd4096;
         tap_last_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDTH:      width_ff    <= csr_wdata[10:0];
            CSR_HEIGHT:     height_ff   <= csr_wdata[15:0];
            CSR_TAPS_FIRST: taps_lo_ff  <= csr_wdata;
            CSR_TAPS_NEXT:  taps_hi_ff  <= csr_wdata;
            CSR_TAP_LAST:   tap_last_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // second push of a drain that did not yet reach a result
   assign extra_in = !extra_ff && accept && !is_pixel && push_go && !ctrl_now.emit;

   // results owed: in flight or queued
   assign pop        = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + (FIFO_AW+1)'(push_go && ctrl_now.emit)
                       - (FIFO_AW+1)'(pop);

   // counters
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lead_ff    <= '0;
         extra_ff   <= 1'b0;
         pending_ff <= '0;
      end else begin
         extra_ff   <= extra_in;
         pending_ff <= pending_in;
         if (size_write) begin
            in_col_ff  <= '0;
            in_row_ff  <= '0;
            out_col_ff <= '0;
            out_row_ff <= '0;
            lead_ff    <= '0;
         end else if (push_go) begin
            in_col_ff  <= in_col_in;
            in_row_ff  <= in_row_in;
            out_col_ff <= out_col_in;
            out_row_ff <= out_row_in;
            lead_ff    <= lead_in;
         end
      end
   end

   // row store read for the new push
   always_ff @(posedge clock) begin
      if (push_go) begin
         rd_new_ff <= mem_new[c_sel];
         rd_old_ff <= mem_old[c_sel];
      end
   end

   // window stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         w_vld_ff <= 1'b0;
      end else begin
         w_vld_ff <= push_go;
      end
   end

   always_ff @(posedge clock) begin
      if (push_go) begin
         w_real_ff   <= push_real;
         w_pix_ff    <= {req_blue_in, req_green_in, req_red_in};
         w_c_ff      <= c_sel;
         w_rowsel_ff <= rowsel_now;
         w_ctrl_ff   <= ctrl_now;
         w_fwd_ff    <= w_vld_ff && (w_c_ff == c_sel);
      end
   end

   // new column from the row stores, with bypass of the write in flight
   always_comb begin
      on_pix = w_fwd_ff ? fwd_new_ff : rd_new_ff;
      oo_pix = w_fwd_ff ? fwd_old_ff : rd_old_ff;
      v_pix  = w_real_ff ? w_pix_ff : on_pix;
      case (w_rowsel_ff)
         ROW_FIRST: begin
            top_pix = v_pix;
            mid_pix = v_pix;
         end
         ROW_SECOND: begin
            top_pix = on_pix;
            mid_pix = on_pix;
         end
         default: begin
            top_pix = oo_pix;
            mid_pix = on_pix;
         end
      endcase
      new_col[0] = top_pix;
      new_col[1] = mid_pix;
      new_col[2] = v_pix;
   end

   // row store write and bypass copy
   always_ff @(posedge clock) begin
      if (w_vld_ff) begin
         mem_new[w_c_ff] <= v_pix;
         mem_old[w_c_ff] <= mid_pix;
         fwd_new_ff      <= v_pix;
         fwd_old_ff      <= mid_pix;
      end
   end

   // tap unpacking
   always_comb begin
      for (int i = 0; i < KTAPS; i++) begin
         if (i < 4) begin
            tap_val[i] = taps_lo_ff[i*TAP_W +: TAP_W];
         end else if (i < 8) begin
            tap_val[i] = taps_hi_ff[(i-4)*TAP_W +: TAP_W];
         end else begin
            tap_val[i] = tap_last_ff;
         end
      end
   end

   // fold edge taps into the centre column where the border repeats
   always_comb begin
      coef_type tl, tc, tr;
      for (int r = 0; r < KROWS; r++) begin
         tl = COEF_W'(tap_val[r*KCOLS]);
         tc = COEF_W'(tap_val[r*KCOLS + 1]);
         tr = COEF_W'(tap_val[r*KCOLS + 2]);
         coef_in[0][r] = w_ctrl_ff.left_rep ? '0 : tl;
         coef_in[2][r] = w_ctrl_ff.right_rep ? '0 : tr;
         coef_in[1][r] = tc + (w_ctrl_ff.left_rep ? tl : '0)
                         + (w_ctrl_ff.right_rep ? tr : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (w_vld_ff) begin
         for (int j = 0; j < KCOLS; j++) begin
            coef_ff[j] <= coef_in[j];
         end
      end
   end

   // row of window cells, data moves right to left
   for (genvar j = 0; j < KCOLS; j++) begin : g_cell
      if (j == KCOLS - 1) begin : g_last
         assign cell_in[j] = new_col;
      end else begin : g_inner
         assign cell_in[j] = cell_col[j+1];
      end

      rkc_cell u_cell (
         .clock    (clock),
         .shift_en (w_vld_ff),
         .col_in   (cell_in[j]),
         .coef_in  (coef_ff[j]),
         .col_out  (cell_col[j]),
         .csum_out (cell_sum[j])
      );
   end

   // result tracking alongside the products and column sums
   always_ff @(posedge clock) begin
      if (reset) begin
         c1_vld_ff <= 1'b0;
         c2_vld_ff <= 1'b0;
         c3_vld_ff <= 1'b0;
      end else begin
         c1_vld_ff <= w_vld_ff && w_ctrl_ff.emit;
         c2_vld_ff <= c1_vld_ff;
         c3_vld_ff <= c2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      c1_fend_ff <= w_ctrl_ff.frame_end;
      c2_fend_ff <= c1_fend_ff;
      c3_fend_ff <= c2_fend_ff;
   end

   // final sum, floor and clamp
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         acc[ch] = ACC_W'($signed(cell_sum[0][ch])) + ACC_W'($signed(cell_sum[1][ch]))
                   + ACC_W'($signed(cell_sum[2][ch]));
         if (acc[ch][ACC_W-1] || (acc[ch] == '0)) begin
            res_item.pix[ch] = PIX_MIN;
         end else if (|acc[ch][ACC_W-1:TAP_FRAC_BITS+PIX_W]) begin
            res_item.pix[ch] = PIX_MAX;
         end else begin
            res_item.pix[ch] = acc[ch][TAP_FRAC_BITS +: PIX_W];
         end
      end
      res_item.frame_end = c3_fend_ff;
   end

   rkc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (c3_vld_ff),
      .push_item (res_item),
      .pop_en    (pop),
      .head_item (head_item),
      .not_empty (fifo_ne)
   );

   assign rsp_valid     = fifo_ne;
   assign rsp_red_out   = head_item.pix[0];
   assign rsp_green_out = head_item.pix[1];
   assign rsp_blue_out  = head_item.pix[2];
   assign rsp_frame_end = head_item.frame_end;

endmodule

`default_nettype wire

FILE: bench/tb_rgb_kernel_convolution_3x3.sv
// self-checking testbench for the rgb 3x3 convolution block
`timescale 1ns / 1ps

module tb_rgb_kernel_convolution_3x3;
   import rkc_pkg::*;

   // register indexes
   localparam logic [2:0] REG_WIDTH  = 3'd0;
   localparam logic [2:0] REG_HEIGHT = 3'd1;
   localparam logic [2:0] REG_TAPS_LO = 3'd2;
   localparam logic [2:0] REG_TAPS_HI = 3'd3;
   localparam logic [2:0] REG_TAP_8  = 3'd4;
   // request actions
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_DRAIN = 1'b1;
   localparam int   MAXW      = 1024;
   localparam int   FRAC      = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = 1'b0;
   logic [7:0]  req_red_in = '0, req_green_in = '0, req_blue_in = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out;
   logic        rsp_frame_end;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   rgb_kernel_convolution_3x3 u_dut (.*);

   initial forever #10 clock = ~clock;

   // run limit
   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

   // filter model state
   logic [10:0] width_reg;
   logic [15:0] height_reg;
   logic [63:0] taps_lo, taps_hi;
   logic [15:0] tap_8;
   logic [23:0] older_row [MAXW];
   logic [23:0] newer_row [MAXW];
   logic [23:0] win [9];
   int in_col, in_row, out_col, out_row, lead;

   rsp_item_type pixels_due [$];
   int errors = 0;
   int sent = 0;
   bit burst_mode = 0;

   function automatic int eff_w();
      if (width_reg < 1) return 1;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
   endfunction

   function automatic int eff_h();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   function automatic int tap_at(int i);
      logic signed [15:0] t;
      if (i < 4) t = taps_lo[16*i +: 16];
      else if (i < 8) t = taps_hi[16*(i-4) +: 16];
      else t = tap_8;
      return t;
   endfunction

   function automatic void clear_counters();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0; lead = 0;
   endfunction

   function automatic logic [23:0] filter_window(int s0, int s1, int s2);
      logic [23:0] res;
      int sel [3];
      int acc, q;
      res = '0;
      sel[0] = s0; sel[1] = s1; sel[2] = s2;
      for (int ch = 0; ch < 3; ch++) begin
         acc = 0;
         for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 3; dx++)
               acc += int'(win[sel[dx]*3 + dy][8*ch +: 8]) * tap_at(dy*3 + dx);
         q = 0;
         if (acc > 0) begin
            q = acc >>> FRAC;
            if (q > 255) q = 255;
         end
         res[8*ch +: 8] = q[7:0];
      end
      return res;
   endfunction

   // one shift through the row stores and window
   function automatic bit advance_window(bit real_pix, logic [23:0] pix,
                                         output logic [23:0] outp, output bit fend);
      int w, h, c, rowidx;
      logic [23:0] on, oo, top, mid, v;
      bit emit;
      w = eff_w(); h = eff_h();
      c = (in_col < w) ? in_col : 0;
      rowidx = real_pix ? in_row : h;
      on = newer_row[c]; oo = older_row[c];
      v = real_pix ? pix : on;
      if (rowidx == 0) begin top = v; mid = v; end
      else if (rowidx == 1) begin top = on; mid = on; end
      else begin top = oo; mid = on; end
      lead++;
      emit = lead > w + 1;
      outp = '0; fend = 0;
      if (emit && c == 0) outp = filter_window((w >= 2) ? 1 : 2, 2, 2);
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      win[6] = top; win[7] = mid; win[8] = v;
      if (emit && c != 0) outp = filter_window((c == 1) ? 1 : 0, 1, 2);
      older_row[c] = mid;
      newer_row[c] = v;
      in_col = c + 1;
      if (in_col >= w) begin
         in_col = 0;
         if (real_pix && in_row < h) in_row++;
      end
      if (emit) begin
         lead = w + 1;
         fend = (out_row >= h - 1) && (out_col >= w - 1);
         if (fend) clear_counters();
         else if (++out_col >= w) begin
            out_col = 0;
            out_row++;
         end
      end
      return emit;
   endfunction

   function automatic void predict_request(logic act, logic [23:0] pix);
      logic [23:0] outp;
      bit fend, emitted;
      rsp_item_type e;
      emitted = 0;
      if (act == ACT_PIXEL) begin
         if (in_row >= eff_h()) clear_counters();
         emitted = advance_window(1, pix, outp, fend);
      end else if (in_row >= eff_h()) begin
         for (int t = 0; t < 2 && !emitted; t++)
            emitted = advance_window(0, '0, outp, fend);
      end
      if (emitted) begin
         e.frame_end = fend;
         e.pix[0] = outp[7:0];
         e.pix[1] = outp[15:8];
         e.pix[2] = outp[23:16];
         pixels_due.push_back(e);
      end
   endfunction

   // values seen just before each rising edge
   logic s_req_ready, s_rsp_valid, s_rsp_ready;
   rsp_item_type s_rsp;
   always @(negedge clock) begin
      s_req_ready <= req_ready;
      s_rsp_valid <= rsp_valid;
      s_rsp_ready <= rsp_ready;
      s_rsp.frame_end <= rsp_frame_end;
      s_rsp.pix <= {rsp_blue_out, rsp_green_out, rsp_red_out};
   end

   // result checker
   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && s_rsp_valid && s_rsp_ready) begin
         if (pixels_due.size() == 0) begin
            $display("%0t: result with none expected: actual %h", $time, s_rsp);
            errors++;
         end else begin
            e = pixels_due.pop_front();
            for (int ch = 0; ch < 3; ch++)
               if (e.pix[ch] !== s_rsp.pix[ch]) begin
                  $display("%0t: channel %0d expected %h actual %h",
                           $time, ch, e.pix[ch], s_rsp.pix[ch]);
                  errors++;
               end
            if (e.frame_end !== s_rsp.frame_end) begin
               $display("%0t: frame_end expected %b actual %b",
                        $time, e.frame_end, s_rsp.frame_end);
               errors++;
            end
         end
      end
   end

   // result back-pressure: quiet stretches, short stalls, rare long stalls
   int stall_left = 0;
   int phase_cnt = 0;
   always @(posedge clock) begin
      int r;
      phase_cnt++;
      r = $urandom_range(0, 99);
      if (reset) rsp_ready <= 1'b0;
      else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if ((phase_cnt / 700) % 3 == 0) rsp_ready <= 1'b1;
      else if (r < 2) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(10, 40);
      end else if (r < 25) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 3);
      end else rsp_ready <= 1'b1;
   end

   function automatic int pick_gap();
      int r;
      if (burst_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // send one request and predict its result once it is taken
   task automatic send_request(logic act, logic [23:0] pix);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_red_in <= pix[7:0];
      req_green_in <= pix[15:8];
      req_blue_in <= pix[23:16];
      do @(posedge clock); while (!s_req_ready);
      predict_request(act, pix);
      sent++;
   endtask

   // write a register once the block has gone quiet
   task automatic write_reg(logic [2:0] idx, logic [63:0] val);
      req_valid <= 1'b0;
      wait (pixels_due.size() == 0);
      repeat (16) @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_WIDTH:   begin width_reg = val[10:0]; clear_counters(); end
         REG_HEIGHT:  begin height_reg = val[15:0]; clear_counters(); end
         REG_TAPS_LO: taps_lo = val;
         REG_TAPS_HI: taps_hi = val;
         REG_TAP_8:   tap_8 = val[15:0];
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick_tap();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'h1000;
         4: return 16'(int'($urandom_range(0, 8192)) - 4096);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_random_taps();
      write_reg(REG_TAPS_LO, {pick_tap(), pick_tap(), pick_tap(), pick_tap()});
      write_reg(REG_TAPS_HI, {pick_tap(), pick_tap(), pick_tap(), pick_tap()});
      write_reg(REG_TAP_8, {48'd0, pick_tap()});
   endtask

   function automatic logic [23:0] edge_pixel();
      case ($urandom_range(0, 3))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // small frames, early and idle drains, extreme taps
   task automatic test_directed();
      write_reg(REG_WIDTH, 64'd3);
      write_reg(REG_HEIGHT, 64'd2);
      write_reg(REG_TAPS_LO, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
      write_reg(REG_TAPS_HI, {16'h1000, 16'h0800, 16'hF000, 16'h7FFF});
      write_reg(REG_TAP_8, 64'hFFFF_FFFF_FFFF_8000);
      send_request(ACT_DRAIN, 24'h0);          // early drain
      send_request(ACT_PIXEL, 24'hFFFFFF);
      send_request(ACT_PIXEL, 24'h000000);
      send_request(ACT_PIXEL, 24'hFF00FF);
      send_request(ACT_PIXEL, 24'h00FF00);
      send_request(ACT_PIXEL, 24'h123456);
      send_request(ACT_PIXEL, 24'hFEDCBA);
      repeat (5) send_request(ACT_DRAIN, 24'h0); // last one is idle
      // single row frame
      write_reg(REG_WIDTH, 64'd2);
      write_reg(REG_HEIGHT, 64'd1);
      send_request(ACT_PIXEL, 24'hFFFFFF);
      send_request(ACT_PIXEL, 24'h010203);
      repeat (3) send_request(ACT_DRAIN, 24'h0);
      // width and height of zero act as one
      write_reg(REG_WIDTH, 64'd0);
      write_reg(REG_HEIGHT, 64'd0);
      send_request(ACT_PIXEL, 24'h80FF7F);
      repeat (2) send_request(ACT_DRAIN, 24'h0);
   endtask

   // widest rows and tallest frame setting
   task automatic test_size_extremes();
      write_random_taps();
      write_reg(REG_WIDTH, 64'h7FF);
      write_reg(REG_HEIGHT, 64'd2);
      // a little past one full row so the second row reads the row stores
      repeat (MAXW + 8) send_request(ACT_PIXEL, 24'($urandom));
      write_reg(REG_WIDTH, 64'd1024);
      write_reg(REG_HEIGHT, 64'hFFFF);
      repeat (12) send_request(ACT_PIXEL, edge_pixel());
      // height write drops the frame in progress
      write_reg(REG_HEIGHT, 64'd1);
      repeat (2) send_request(ACT_DRAIN, 24'h0);
   endtask

   // random small frames with random content, noise and cut-off frames
   task automatic test_random_frames(int count);
      int start, w, h, npix;
      start = sent;
      while (sent - start < count) begin
         burst_mode = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) == 0) write_random_taps();
         if ($urandom_range(0, 1) == 0 || eff_w() > 16) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            h = $urandom_range(1, 5);
            write_reg(REG_WIDTH, 64'(w));
            write_reg(REG_HEIGHT, 64'(h));
         end
         npix = eff_w() * eff_h();
         if ($urandom_range(0, 9) == 0) npix = $urandom_range(1, npix);
         for (int i = 0; i < npix; i++) begin
            if ($urandom_range(0, 19) == 0) send_request(ACT_DRAIN, 24'($urandom));
            send_request(ACT_PIXEL, edge_pixel());
         end
         // sometimes go straight on to the next frame with results pending
         if ($urandom_range(0, 9) != 0)
            repeat (eff_w() + 1 + $urandom_range(0, 2)) send_request(ACT_DRAIN, 24'($urandom));
      end
      burst_mode = 0;
   endtask

   initial begin
      width_reg = 11'd640;
      height_reg = 16'd480;
      taps_lo = '0;
      taps_hi = 64'd4096;
      tap_8 = '0;
      for (int i = 0; i < 9; i++) win[i] = '0;
      for (int i = 0; i < MAXW; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      clear_counters();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults pass the centre tap through
      write_reg(REG_HEIGHT, 64'd2);
      write_reg(REG_WIDTH, 64'd2);
      repeat (4) send_request(ACT_PIXEL, edge_pixel());
      repeat (3) send_request(ACT_DRAIN, 24'h0);

      test_directed();
      test_random_frames(500);
      test_size_extremes();

      req_valid <= 1'b0;
      wait (pixels_due.size() == 0);
      repeat (30) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
